// File: hw/rtl/pwm_compare_stage_and_commit_macros.svh
// ----------------------------------------------------------------------------
// PWM compare staging assertion macros
// Shared concurrent assertion forms for the compare stage and commit block.
// ----------------------------------------------------------------------------
`ifndef PWM_COMPARE_STAGE_AND_COMMIT_MACROS_SVH
`define PWM_COMPARE_STAGE_AND_COMMIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PCSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcsc same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PCSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcsc next-cycle check failed");

`endif

// File: hw/rtl/pcsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM compare staging package
// Types, codes and constants shared by the compare staging modules.
// ----------------------------------------------------------------------------
package pcsc_pkg;

   localparam int CMP_W = 11;

   // Item kinds carried on the request side.
   localparam logic REQ_STAGE  = 1'b0;
   localparam logic REQ_COMMIT = 1'b1;

   // Interrupt arming codes.
   localparam logic [1:0] IRQ_NONE     = 2'd0;
   localparam logic [1:0] IRQ_COMPARE  = 2'd1;
   localparam logic [1:0] IRQ_OVERFLOW = 2'd2;

   // Compare masks: 11 bits at the fast clock, 10 bits otherwise.
   localparam logic [CMP_W-1:0] CMP_MASK_FAST = 11'h7FF;
   localparam logic [CMP_W-1:0] CMP_MASK_SLOW = 11'h3FF;

   // Configuration register indexes.
   localparam logic CSR_FAST_CLOCK = 1'b0;
   localparam logic CSR_FET_DELAY  = 1'b1;

   typedef struct packed {
      logic [CMP_W-1:0] power;
      logic [CMP_W-1:0] damping;
      logic             damping_en;
   } cmp_set_type;

   typedef struct packed {
      cmp_set_type pending;
      logic        pend_vld;
      cmp_set_type current;
      logic        stage_clock;
   } cmp_state_type;

   // Declared high field first so that interrupt_choice lands in the low bits.
   typedef struct packed {
      logic             damp_on;
      logic [CMP_W-1:0] damp_cmp;
      logic [CMP_W-1:0] power_cmp;
      logic             pending_flag;
      logic             disable_ccf;
      logic             damp_commit;
      logic             committed;
      logic [1:0]       interrupt_choice;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

// File: hw/rtl/pcsc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM compare step logic
// Next-state and result logic for one stage or commit beat.
// ----------------------------------------------------------------------------
module pcsc_step import pcsc_pkg::*; (
   input  cmp_state_type st,
   input  logic          fast_clock_mode,
   input  logic [7:0]    fet_delay,
   input  logic          req_type,
   input  logic [7:0]    duty_req,
   input  logic [7:0]    duty_limit,
   input  logic [7:0]    rpm_duty_limit,
   input  logic [7:0]    counter_high,
   output cmp_state_type st_next,
   output rsp_type       rsp
);

   logic [7:0]       lim;
   logic [7:0]       duty;
   logic [CMP_W-1:0] scaled;
   logic [CMP_W-1:0] mask;
   logic [CMP_W-1:0] pc;
   logic [CMP_W-1:0] delay;
   logic [CMP_W-1:0] dc;
   logic             damp_en;
   logic             cur_high_stage;
   logic             cur_high_commit;
   logic             th_bit;
   logic             lo_bit;
   logic             window_ok;
   logic             do_commit;

   always_comb begin
      lim    = (rpm_duty_limit < duty_limit) ? rpm_duty_limit : duty_limit;
      duty   = (lim < duty_req) ? lim : duty_req;
      scaled = fast_clock_mode ? {duty, 3'b000} : {1'b0, duty, 2'b00};
      mask   = fast_clock_mode ? CMP_MASK_FAST : CMP_MASK_SLOW;
      pc     = ~scaled & mask;
      delay  = fast_clock_mode ? {2'b00, fet_delay, 1'b0} : {3'b000, fet_delay};
      dc     = (delay > pc) ? '0 : pc - delay;
      damp_en = (fet_delay != 8'd0);

      // The current compare is "high" when its threshold bit is clear.
      cur_high_stage  = fast_clock_mode ? ~st.current.power[10] : ~st.current.power[9];
      cur_high_commit = st.stage_clock ? ~st.current.power[10] : ~st.current.power[9];
      th_bit = st.stage_clock ? counter_high[2] : counter_high[1];
      lo_bit = st.stage_clock ? counter_high[1] : counter_high[0];
      window_ok = cur_high_commit ? (th_bit & ~lo_bit) : (~th_bit & ~lo_bit);
      do_commit = st.pend_vld & (~st.pending.damping_en | window_ok);

      st_next = st;
      rsp.interrupt_choice = IRQ_NONE;
      rsp.committed        = 1'b0;
      rsp.damp_commit      = 1'b0;
      rsp.disable_ccf      = 1'b0;

      if (req_type == REQ_STAGE) begin
         st_next.pending.power      = pc;
         st_next.pending.damping    = dc;
         st_next.pending.damping_en = damp_en;
         st_next.pend_vld           = 1'b1;
         st_next.stage_clock        = fast_clock_mode;
         if (damp_en || !cur_high_stage) begin
            rsp.interrupt_choice = IRQ_OVERFLOW;
         end else begin
            rsp.interrupt_choice = IRQ_COMPARE;
         end
      end else if (do_commit) begin
         st_next.current   = st.pending;
         st_next.pend_vld  = 1'b0;
         rsp.committed     = 1'b1;
         rsp.damp_commit   = st.pending.damping_en;
         rsp.disable_ccf   = ~st.pending.damping_en;
      end

      rsp.pending_flag = st_next.pend_vld;
      rsp.power_cmp    = st_next.current.power;
      rsp.damp_cmp     = st_next.current.damping;
      rsp.damp_on      = st_next.current.damping_en;
   end

endmodule

// File: hw/rtl/pwm_compare_stage_and_commit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM compare stage and commit
// Double-buffered motor PWM compare staging with a windowed commit.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Contents
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | tvalid / tready      | stage or commit beat
//   rsp     | out       | tvalid / tready      | one result beat per request beat
//   csr     | in        | csr_wen, no wait     | fast_clock_mode, fet_delay
//
// Each request beat is handled combinationally: the clamp, mask, subtract and
// window check all settle ahead of the state and result registers.
// A new beat is taken every cycle as long as the result register is empty
// or is being drained in the same cycle, so a full rate of one beat per
// cycle holds while rsp_tready stays high. A stall on rsp holds the result
// register and deasserts req_tready until the beat is taken.
// Reset is synchronous and active high; it clears all compare state, the
// configuration registers and the result valid flag.
//
`include "pwm_compare_stage_and_commit_macros.svh"

module pwm_compare_stage_and_commit import pcsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // duty_req[7:0], duty_limit[15:8],
                                    // rpm_duty_limit[23:16], counter_high[31:24]
   input  logic        req_tuser,   // req_type[0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // interrupt_choice[1:0], committed[2],
                                    // damp_commit[3], disable_ccf[4],
                                    // pending_flag[5], power_cmp[16:6],
                                    // damp_cmp[27:17], damp_on[28],
                                    // zero fill[31:29]
   // Configuration write port.
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata
);

   cmp_state_type st_ff, st_in;
   rsp_type       out_ff, out_in;
   logic          out_vld_ff, out_vld_in;
   logic          fast_ff;
   logic [7:0]    delay_ff;
   logic          req_accept;

   // The result register can take a new beat when it is empty or draining.
   assign req_tready = ~out_vld_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   pcsc_step u_step (
      .st              (st_ff),
      .fast_clock_mode (fast_ff),
      .fet_delay       (delay_ff),
      .req_type        (req_tuser),
      .duty_req        (req_tdata[7:0]),
      .duty_limit      (req_tdata[15:8]),
      .rpm_duty_limit  (req_tdata[23:16]),
      .counter_high    (req_tdata[31:24]),
      .st_next         (st_in),
      .rsp             (out_in)
   );

   assign out_vld_in = req_accept | (out_vld_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= '0;
         out_vld_ff <= 1'b0;
         fast_ff    <= 1'b0;
         delay_ff   <= 8'd0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (req_accept) begin
            st_ff <= st_in;
         end
         if (csr_wen) begin
            case (csr_addr)
               CSR_FAST_CLOCK: fast_ff  <= csr_wdata[0];
               CSR_FET_DELAY:  delay_ff <= csr_wdata;
               default:        ;
            endcase
         end
      end
   end

   // Result payload needs no reset; it is qualified by out_vld_ff.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(32 - RSP_W){1'b0}}, out_ff};

   // A commit always picks exactly one of the two interrupt follow-ups.
   `PCSC_ASSERT_IMP(a_commit_flags_onehot, clock, reset,
      out_vld_ff && out_ff.committed, out_ff.damp_commit != out_ff.disable_ccf)
   // Stage beats arm an interrupt and never report a commit.
   `PCSC_ASSERT_IMP(a_stage_no_commit, clock, reset,
      out_vld_ff && out_ff.interrupt_choice != IRQ_NONE, !out_ff.committed)
   // Accepting a stage beat leaves a request pending.
   `PCSC_ASSERT_NXT(a_stage_sets_pending, clock, reset,
      req_accept && req_tuser == REQ_STAGE, st_ff.pend_vld && out_ff.pending_flag)
   // A reported commit leaves nothing pending.
   `PCSC_ASSERT_IMP(a_commit_clears_pending, clock, reset,
      out_vld_ff && out_ff.committed, !out_ff.pending_flag)

endmodule
